### design/gm5_pkg.sv
// ----------------------------------------------------------------------------
// gm5_pkg
// Shared constants for the gated median-of-five current filter.
// ----------------------------------------------------------------------------
`default_nettype none

package gm5_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int WIN_LEN          = 5;
    localparam int PTR_W            = $clog2(WIN_LEN);
    localparam int RANK_W           = $clog2(WIN_LEN);
    localparam logic [RANK_W-1:0] MED_RANK = RANK_W'(WIN_LEN / 2);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(WIN_LEN - 1);

endpackage

`default_nettype wire

### design/gm5_median.sv
// ----------------------------------------------------------------------------
// gm5_median
// Combinational median of the five window entries by rank counting.
// ----------------------------------------------------------------------------
`default_nettype none

module gm5_median #(
    parameter int SAMPLE_WIDTH = gm5_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_win [gm5_pkg::WIN_LEN],
    output logic signed [SAMPLE_WIDTH-1:0]      o_median
);

    logic [gm5_pkg::RANK_W-1:0] rank [gm5_pkg::WIN_LEN];

    // Each entry counts the entries ordered below it. Equal values are
    // ordered by position, so the ranks are a permutation and exactly one
    // entry holds the middle rank.
    always_comb begin
        for (int i = 0; i < gm5_pkg::WIN_LEN; i++) begin
            rank[i] = '0;
            for (int j = 0; j < gm5_pkg::WIN_LEN; j++) begin
                if (j < i) begin
                    if (i_win[j] <= i_win[i]) begin
                        rank[i] = rank[i] + 1'b1;
                    end
                end else if (j > i) begin
                    if (i_win[j] < i_win[i]) begin
                        rank[i] = rank[i] + 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        o_median = '0;
        for (int i = 0; i < gm5_pkg::WIN_LEN; i++) begin
            if (rank[i] == gm5_pkg::MED_RANK) begin
                o_median = i_win[i];
            end
        end
    end

endmodule

`default_nettype wire

### design/gm5_window.sv
// ----------------------------------------------------------------------------
// gm5_window
// Five-entry sample ring with write pointer and window-full flag.
// ----------------------------------------------------------------------------
`default_nettype none

module gm5_window #(
    parameter int SAMPLE_WIDTH = gm5_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_load,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic signed [SAMPLE_WIDTH-1:0]      o_win_next [gm5_pkg::WIN_LEN],
    output logic                                o_full_next
);

    logic signed [SAMPLE_WIDTH-1:0] r_win [gm5_pkg::WIN_LEN];
    logic [gm5_pkg::PTR_W-1:0]      r_ptr;
    logic [gm5_pkg::PTR_W-1:0]      n_ptr;
    logic                           r_full;
    logic                           w_write;
    logic                           w_wrap;

    // Only strictly positive samples enter the ring.
    assign w_write = i_load && !i_sample[SAMPLE_WIDTH-1] && (i_sample != '0);
    assign w_wrap  = (r_ptr == gm5_pkg::PTR_LAST);
    assign n_ptr   = w_wrap ? '0 : r_ptr + 1'b1;

    assign o_full_next = r_full || (w_write && w_wrap);

    // The median sees the window including the sample of the same item.
    always_comb begin
        for (int i = 0; i < gm5_pkg::WIN_LEN; i++) begin
            if (w_write && (r_ptr == gm5_pkg::PTR_W'(i))) begin
                o_win_next[i] = i_sample;
            end else begin
                o_win_next[i] = r_win[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_full <= 1'b0;
        end else if (w_write) begin
            r_ptr  <= n_ptr;
            r_full <= o_full_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= o_win_next;
    end

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= gm5_pkg::PTR_LAST)
        else $error("write pointer left the ring");

    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |=> r_full)
        else $error("window-full flag cleared without reset");

    a_ptr_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_write |=> (r_ptr == $past(r_ptr)))
        else $error("write pointer moved without a stored sample");

endmodule

`default_nettype wire

### design/gated_median5_current_filter.sv
// ----------------------------------------------------------------------------
// gated_median5_current_filter
// Running median-of-five filter for signed motor-current samples.
// ----------------------------------------------------------------------------
// One item is accepted per clock cycle while o_stall is low. The sample
// is captured in an input register, then the ring update and the
// rank-counting median of five run as one combinational stage into the
// result register. Positive samples are stored in the five-entry ring;
// until the ring has wrapped once the sample is passed through, afterwards
// the median of the ring is returned with o_median_used set. A stalled
// result leaves room for one more item in the input register.
`default_nettype none

module gated_median5_current_filter #(
    parameter int SAMPLE_WIDTH = gm5_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic signed [SAMPLE_WIDTH-1:0]      o_filtered,
    output logic                                o_median_used
);

    logic                           r_in_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_in_sample;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_filtered;
    logic                           r_out_used;

    logic                           w_out_free;
    logic                           w_advance;
    logic                           w_accept;
    logic signed [SAMPLE_WIDTH-1:0] w_win_next [gm5_pkg::WIN_LEN];
    logic                           w_full_next;
    logic signed [SAMPLE_WIDTH-1:0] w_median;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_stall    = r_in_valid && !w_out_free;
    assign w_accept   = i_valid && !o_stall;

    gm5_window #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_advance),
        .i_sample    (r_in_sample),
        .o_win_next  (w_win_next),
        .o_full_next (w_full_next)
    );

    gm5_median #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_median (
        .i_win    (w_win_next),
        .o_median (w_median)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_sample <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_filtered <= w_full_next ? w_median : r_in_sample;
            r_out_used     <= w_full_next;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_filtered    = r_out_filtered;
    assign o_median_used = r_out_used;

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with a free pipeline");

endmodule

`default_nettype wire

### sim/median5_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median5_result_checker
// Watches both channels of the gated median-of-five filter. It keeps its own
// ring of positive samples, predicts the result of every accepted item and
// compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------

module median5_result_checker #(
    parameter int SAMPLE_WIDTH = gm5_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_filtered,
    input  wire logic                           i_median_used,
    output int                                  o_errors,
    output int                                  o_pending,
    output int                                  o_medians
);

    typedef logic signed [SAMPLE_WIDTH-1:0] t_current;

    typedef struct {
        t_current filtered;
        logic     median_used;
    } t_filter_result;

    t_current                  ring [gm5_pkg::WIN_LEN];
    logic [gm5_pkg::PTR_W-1:0] wr_ptr;
    logic                      ring_full;
    t_filter_result            expected_q [$];
    int                        errors  = 0;
    int                        medians = 0;

    // The value whose rank range covers the middle position is the median,
    // which also settles ties without a sort.
    function automatic t_current ring_median();
        int       i;
        int       j;
        int       below;
        int       not_above;
        t_current med;
        med = ring[0];
        for (i = 0; i < gm5_pkg::WIN_LEN; i++) begin
            below     = 0;
            not_above = 0;
            for (j = 0; j < gm5_pkg::WIN_LEN; j++) begin
                if (ring[j] < ring[i]) below++;
                if (ring[j] <= ring[i]) not_above++;
            end
            if (below <= int'(gm5_pkg::MED_RANK) && not_above > int'(gm5_pkg::MED_RANK))
                med = ring[i];
        end
        return med;
    endfunction

    task automatic predict_result(input t_current s);
        t_filter_result r;
        if (s > 0) begin
            ring[wr_ptr] = s;
            if (wr_ptr == gm5_pkg::PTR_LAST) begin
                wr_ptr    = '0;
                ring_full = 1'b1;
            end else begin
                wr_ptr = wr_ptr + 1'b1;
            end
        end
        r.median_used = ring_full;
        r.filtered    = ring_full ? ring_median() : s;
        expected_q.push_back(r);
    endtask

    task automatic check_result();
        t_filter_result want;
        if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: result with no item pending: filtered=%0d median_used=%0b",
                     $time, i_filtered, i_median_used);
        end else begin
            want = expected_q.pop_front();
            if (i_filtered !== want.filtered) begin
                errors++;
                $display("%0t: filtered mismatch: expected %0d, actual %0d",
                         $time, want.filtered, i_filtered);
            end
            if (i_median_used !== want.median_used) begin
                errors++;
                $display("%0t: median_used mismatch: expected %0b, actual %0b",
                         $time, want.median_used, i_median_used);
            end
            if (want.median_used) medians++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wr_ptr    = '0;
            ring_full = 1'b0;
            expected_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) predict_result(i_sample);
            if (i_out_valid && !i_out_stall) check_result();
        end
        o_errors  <= errors;
        o_pending <= expected_q.size();
        o_medians <= medians;
    end

endmodule

### sim/gated_median5_current_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_median5_current_filter_tb
// Drives signed current samples into the median-of-five filter with random
// gaps and output stalls, and gives the verdict from the checker's counts.
// ----------------------------------------------------------------------------

module gated_median5_current_filter_tb;

    localparam int SW             = gm5_pkg::SAMPLE_WIDTH_DEF;
    localparam int N_RANDOM       = 1600;
    localparam int N_DIRECTED     = 23;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int HOLDOFF_CYCLES = 200;
    localparam int HOLDOFF_AFTER  = 400;
    localparam int DRAIN_AT       = 1000;
    localparam int TAIL_CYCLES    = 20;

    typedef logic signed [SW-1:0] t_sample;

    // Pass-through extremes and negatives mixed with the five positive
    // samples that fill the ring, then stored and unstored samples once it
    // is full, including runs of equal values.
    localparam t_sample DIRECTED [N_DIRECTED] = '{
        16'sh8000, 16'sh0000, 16'shFFFF, 16'sh7FFF, 16'sh8001, 16'sh0001,
        16'sh0001, 16'sh0000, 16'sh5555, 16'shFFFE, 16'sh2AAA, 16'sh8000,
        16'sh0000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'shFFFF, 16'sh0007,
        16'sh0007, 16'sh0007, 16'sh0007, 16'sh0007, 16'sh0001
    };

    logic    i_clk;
    logic    i_rst_n;
    logic    i_valid;
    logic    i_stall;
    t_sample i_sample;
    logic    o_stall;
    logic    o_valid;
    t_sample o_filtered;
    logic    o_median_used;

    int   errors;
    int   pending;
    int   medians;
    int   sent_items   = 0;
    int   nonpos_items = 0;
    int   cycle_count  = 0;
    int   stall_left   = 0;
    bit   holdoff_done = 1'b0;
    int   n;
    int   k;
    logic calm;

    // Every fourth stretch of 200 items runs with no gaps and no stalls.
    assign calm = ((sent_items / 200) % 4) == 1;

    gated_median5_current_filter #(
        .SAMPLE_WIDTH(SW)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_filtered   (o_filtered),
        .o_median_used(o_median_used)
    );

    median5_result_checker #(
        .SAMPLE_WIDTH(SW)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_sample     (i_sample),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_filtered   (o_filtered),
        .i_median_used(o_median_used),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_medians    (medians)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_sample random_sample();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return t_sample'($urandom_range(1, 32767));
        if (r < 65) return t_sample'($urandom_range(1, 12));
        if (r < 72) return t_sample'(32768 - $urandom_range(1, 3));
        if (r < 90) return {1'b1, 15'($urandom)};
        if (r < 95) return '0;
        if (r < 98) return '1;
        return {1'b1, {(SW-1){1'b0}}};
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_sample(input t_sample s);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        sent_items <= sent_items + 1;
        if (s <= 0) nonpos_items++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Receiver: random stalls, plus one long hold-off while items keep coming.
    initial begin
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!holdoff_done && sent_items >= HOLDOFF_AFTER) begin
                holdoff_done = 1'b1;
                stall_left   = HOLDOFF_CYCLES - 1;
                i_stall <= 1'b1;
            end else if (calm) begin
                i_stall <= 1'b0;
            end else begin
                k = $urandom_range(0, 99);
                if (k < 70) begin
                    i_stall <= 1'b0;
                end else if (k < 97) begin
                    stall_left = $urandom_range(0, 2);
                    i_stall <= 1'b1;
                end else begin
                    stall_left = $urandom_range(8, 40);
                    i_stall <= 1'b1;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still pending", cycle_count, pending);
        $display("simulation failed");
        $finish;
    end

    initial begin
        i_rst_n  <= 1'b0;
        i_valid  <= 1'b0;
        i_sample <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < N_DIRECTED; n++) send_sample(DIRECTED[n]);
        drain_results();

        for (n = 0; n < N_RANDOM; n++) begin
            // The sender waits once mid-run until every result is back.
            if (n == DRAIN_AT) drain_results();
            send_sample(random_sample());
        end
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d items sent (%0d of them zero or negative), %0d median results",
                 N_DIRECTED + N_RANDOM, nonpos_items, medians);
        $display("one receiver hold-off of %0d cycles, %0d cycles in total",
                 HOLDOFF_CYCLES, cycle_count);
        if (errors == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
